### rtl/core/oate_pkg.sv
// ----------------------------------------------------------------------------
// oate_pkg
// shared types, codes and sizes for the ordered array table engine
// ----------------------------------------------------------------------------
package oate_pkg;

  localparam int DEPTH = 32;
  localparam int WIDTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 6;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_APPEND   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_DEL_LAST = 3'd3,
    OP_REVERSE  = 3'd4,
    OP_SUM      = 3'd5,
    OP_SEARCH   = 3'd6,
    OP_READ     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_BADPOS   = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] data_out;
    logic [5:0]         found_at;
    logic [5:0]         fill_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_DN_RD,
    S_DN_WR,
    S_DROP,
    S_RV_RA,
    S_RV_RB,
    S_RV_WA,
    S_RV_WB,
    S_SCAN_RD,
    S_SCAN_EV,
    S_RD,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    I_KEEP,
    I_CNT,
    I_POS,
    I_ZERO,
    I_INC,
    I_DEC
  } i_op_t;

  typedef enum logic [1:0] {
    J_KEEP,
    J_LAST,
    J_DEC
  } j_op_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_I,
    RD_IM1,
    RD_J,
    RD_PM1
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_I_RDQ,
    WR_IM1_RDQ,
    WR_J_HOLD,
    WR_PM1_VAL
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    set_st;
    status_t st;
    i_op_t   i_op;
    j_op_t   j_op;
    logic    pos_app;
    rd_sel_t rd;
    wr_sel_t wr;
    logic    hold_ld;
    logic    acc_add;
    logic    found_ld;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic ins_bad;
    logic pos_bad;
    logic tail;
    logic del_tail;
    logic rev_ok;
    logic i_gt_pos;
    logic i_more;
    logic rev_more;
    logic match;
  } dp_stat_t;

endpackage

### rtl/core/oate_dp.sv
// ----------------------------------------------------------------------------
// oate_dp
// entry memory, fill count, walk indexes, accumulator and result register
// ----------------------------------------------------------------------------
module oate_dp (
  input  logic              clk,
  input  logic              rst,
  input  oate_pkg::req_t    req,
  input  oate_pkg::cmd_t    cmd,
  output oate_pkg::dp_stat_t stat,
  output oate_pkg::rsp_t    rsp,
  output logic              done
);

  oate_pkg::word_t mem [oate_pkg::DEPTH];
  oate_pkg::word_t rdq;
  oate_pkg::word_t hold;
  oate_pkg::word_t acc;
  oate_pkg::word_t val;
  oate_pkg::op_t   op;
  oate_pkg::status_t status;
  logic [oate_pkg::POS_W-1:0] pos;
  oate_pkg::cnt_t  cnt;
  oate_pkg::cnt_t  i;
  oate_pkg::cnt_t  j;
  oate_pkg::cnt_t  found;

  oate_pkg::cnt_t  rd_ptr;
  oate_pkg::cnt_t  wr_ptr;
  oate_pkg::word_t wr_data;
  logic            rd_en;
  logic            wr_en;
  logic [oate_pkg::CNT_W:0] cnt_x;
  logic [oate_pkg::CNT_W:0] pos_x;
  oate_pkg::rsp_t  rsp_next;

  assign cnt_x = {1'b0, cnt};
  assign pos_x = (oate_pkg::CNT_W + 1)'(pos);

  always_comb begin
    stat.op       = op;
    stat.full     = cnt == oate_pkg::CNT_W'(oate_pkg::DEPTH);
    stat.empty    = cnt == '0;
    stat.ins_bad  = (pos_x == '0) || (pos_x > cnt_x + 1'b1);
    stat.pos_bad  = (pos_x == '0) || (pos_x > cnt_x);
    stat.tail     = cnt_x >= pos_x;
    stat.del_tail = pos_x < cnt_x;
    stat.rev_ok   = cnt_x >= (oate_pkg::CNT_W + 1)'(2);
    stat.i_gt_pos = {1'b0, i} > pos_x;
    stat.i_more   = {1'b0, i} + 1'b1 < cnt_x;
    stat.rev_more = {1'b0, i} + (oate_pkg::CNT_W + 1)'(2) < {1'b0, j};
    stat.match    = rdq == val;
  end

  // memory address and data steering
  always_comb begin
    rd_en   = 1'b1;
    rd_ptr  = i;
    unique case (cmd.rd)
      oate_pkg::RD_NONE: rd_en  = 1'b0;
      oate_pkg::RD_I:    rd_ptr = i;
      oate_pkg::RD_IM1:  rd_ptr = i - 1'b1;
      oate_pkg::RD_J:    rd_ptr = j;
      oate_pkg::RD_PM1:  rd_ptr = oate_pkg::CNT_W'(pos) - 1'b1;
      default:           rd_en  = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_ptr  = i;
    wr_data = rdq;
    unique case (cmd.wr)
      oate_pkg::WR_NONE:    wr_en = 1'b0;
      oate_pkg::WR_I_RDQ:   wr_ptr = i;
      oate_pkg::WR_IM1_RDQ: wr_ptr = i - 1'b1;
      oate_pkg::WR_J_HOLD: begin
        wr_ptr  = j;
        wr_data = hold;
      end
      oate_pkg::WR_PM1_VAL: begin
        wr_ptr  = oate_pkg::CNT_W'(pos) - 1'b1;
        wr_data = val;
      end
      default:              wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr[oate_pkg::IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdq <= mem[rd_ptr[oate_pkg::IDX_W-1:0]];
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req.op;
      val <= oate_pkg::WIDTH'(req.value);
      pos <= req.position;
    end else if (cmd.pos_app) begin
      pos <= oate_pkg::POS_W'(cnt_x + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_ld) begin
      hold <= rdq;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + rdq;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status <= oate_pkg::STS_OK;
    end else if (cmd.set_st) begin
      status <= cmd.st;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found <= '0;
    end else if (cmd.found_ld) begin
      found <= i + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.i_op)
      oate_pkg::I_KEEP: i <= i;
      oate_pkg::I_CNT:  i <= cnt;
      oate_pkg::I_POS:  i <= oate_pkg::CNT_W'(pos);
      oate_pkg::I_ZERO: i <= '0;
      oate_pkg::I_INC:  i <= i + 1'b1;
      oate_pkg::I_DEC:  i <= i - 1'b1;
      default:          i <= i;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd.j_op)
      oate_pkg::J_KEEP: j <= j;
      oate_pkg::J_LAST: j <= cnt - 1'b1;
      oate_pkg::J_DEC:  j <= j - 1'b1;
      default:          j <= j;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_comb begin
    rsp_next.status     = status;
    rsp_next.found_at   = 6'(found);
    rsp_next.fill_count = 6'(cnt);
    rsp_next.data_out   = '0;
    if (op == oate_pkg::OP_SUM) begin
      rsp_next.data_out = 32'(signed'(acc));
    end else if (op == oate_pkg::OP_READ && status == oate_pkg::STS_OK) begin
      rsp_next.data_out = 32'(signed'(rdq));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= oate_pkg::CNT_W'(oate_pkg::DEPTH))
    else $error("fill count above depth");

  a_no_grow_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !stat.full)
    else $error("fill count grows on a full table");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

endmodule

### rtl/core/oate_ctrl.sv
// ----------------------------------------------------------------------------
// oate_ctrl
// sequencer: checks the item, then walks the memory one step at a time
// ----------------------------------------------------------------------------
module oate_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  oate_pkg::dp_stat_t stat,
  output oate_pkg::cmd_t     cmd,
  output logic               busy
);

  oate_pkg::state_t state;
  oate_pkg::state_t state_next;

  assign busy = state != oate_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oate_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      oate_pkg::S_IDLE: begin
        if (start) state_next = oate_pkg::S_DECIDE;
      end
      oate_pkg::S_DECIDE: begin
        unique case (stat.op) inside
          oate_pkg::OP_INSERT: begin
            if (stat.full || stat.ins_bad) state_next = oate_pkg::S_FIN;
            else if (stat.tail)            state_next = oate_pkg::S_UP_RD;
            else                           state_next = oate_pkg::S_PUT;
          end
          oate_pkg::OP_APPEND: begin
            state_next = stat.full ? oate_pkg::S_FIN : oate_pkg::S_PUT;
          end
          oate_pkg::OP_DELETE: begin
            if (stat.empty || stat.pos_bad) state_next = oate_pkg::S_FIN;
            else if (stat.del_tail)         state_next = oate_pkg::S_DN_RD;
            else                            state_next = oate_pkg::S_DROP;
          end
          oate_pkg::OP_DEL_LAST: begin
            state_next = stat.empty ? oate_pkg::S_FIN : oate_pkg::S_DROP;
          end
          oate_pkg::OP_REVERSE: begin
            state_next = stat.rev_ok ? oate_pkg::S_RV_RA : oate_pkg::S_FIN;
          end
          oate_pkg::OP_SUM, oate_pkg::OP_SEARCH: begin
            state_next = stat.empty ? oate_pkg::S_FIN : oate_pkg::S_SCAN_RD;
          end
          oate_pkg::OP_READ: begin
            state_next = (stat.empty || stat.pos_bad) ? oate_pkg::S_FIN : oate_pkg::S_RD;
          end
          default: state_next = oate_pkg::S_FIN;
        endcase
      end
      oate_pkg::S_UP_RD: state_next = oate_pkg::S_UP_WR;
      oate_pkg::S_UP_WR: begin
        state_next = stat.i_gt_pos ? oate_pkg::S_UP_RD : oate_pkg::S_PUT;
      end
      oate_pkg::S_PUT:   state_next = oate_pkg::S_FIN;
      oate_pkg::S_DN_RD: state_next = oate_pkg::S_DN_WR;
      oate_pkg::S_DN_WR: begin
        state_next = stat.i_more ? oate_pkg::S_DN_RD : oate_pkg::S_DROP;
      end
      oate_pkg::S_DROP:  state_next = oate_pkg::S_FIN;
      oate_pkg::S_RV_RA: state_next = oate_pkg::S_RV_RB;
      oate_pkg::S_RV_RB: state_next = oate_pkg::S_RV_WA;
      oate_pkg::S_RV_WA: state_next = oate_pkg::S_RV_WB;
      oate_pkg::S_RV_WB: begin
        state_next = stat.rev_more ? oate_pkg::S_RV_RA : oate_pkg::S_FIN;
      end
      oate_pkg::S_SCAN_RD: state_next = oate_pkg::S_SCAN_EV;
      oate_pkg::S_SCAN_EV: begin
        if ((stat.op == oate_pkg::OP_SEARCH && stat.match) || !stat.i_more) begin
          state_next = oate_pkg::S_FIN;
        end else begin
          state_next = oate_pkg::S_SCAN_RD;
        end
      end
      oate_pkg::S_RD:  state_next = oate_pkg::S_FIN;
      oate_pkg::S_FIN: state_next = oate_pkg::S_IDLE;
      default:         state_next = oate_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state)
      oate_pkg::S_IDLE: begin
        cmd.load = start;
      end
      oate_pkg::S_DECIDE: begin
        unique case (stat.op)
          oate_pkg::OP_INSERT: begin
            if (stat.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = oate_pkg::STS_FULL;
            end else if (stat.ins_bad) begin
              cmd.set_st = 1'b1;
              cmd.st     = oate_pkg::STS_BADPOS;
            end else if (stat.tail) begin
              cmd.i_op = oate_pkg::I_CNT;
            end
          end
          oate_pkg::OP_APPEND: begin
            if (stat.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = oate_pkg::STS_FULL;
            end else begin
              // append is an insert just past the last entry
              cmd.pos_app = 1'b1;
            end
          end
          oate_pkg::OP_DELETE: begin
            if (stat.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = oate_pkg::STS_EMPTY;
            end else if (stat.pos_bad) begin
              cmd.set_st = 1'b1;
              cmd.st     = oate_pkg::STS_BADPOS;
            end else if (stat.del_tail) begin
              cmd.i_op = oate_pkg::I_POS;
            end
          end
          oate_pkg::OP_DEL_LAST: begin
            if (stat.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = oate_pkg::STS_EMPTY;
            end
          end
          oate_pkg::OP_REVERSE: begin
            if (stat.rev_ok) begin
              cmd.i_op = oate_pkg::I_ZERO;
              cmd.j_op = oate_pkg::J_LAST;
            end
          end
          oate_pkg::OP_SUM: begin
            cmd.i_op = oate_pkg::I_ZERO;
          end
          oate_pkg::OP_SEARCH: begin
            cmd.i_op = oate_pkg::I_ZERO;
            if (stat.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = oate_pkg::STS_NOTFOUND;
            end
          end
          oate_pkg::OP_READ: begin
            if (stat.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = oate_pkg::STS_EMPTY;
            end else if (stat.pos_bad) begin
              cmd.set_st = 1'b1;
              cmd.st     = oate_pkg::STS_BADPOS;
            end
          end
          default: cmd.set_st = 1'b0;
        endcase
      end
      // shift up: entry i takes entry i-1
      oate_pkg::S_UP_RD: cmd.rd = oate_pkg::RD_IM1;
      oate_pkg::S_UP_WR: begin
        cmd.wr   = oate_pkg::WR_I_RDQ;
        cmd.i_op = oate_pkg::I_DEC;
      end
      oate_pkg::S_PUT: begin
        cmd.wr      = oate_pkg::WR_PM1_VAL;
        cmd.cnt_inc = 1'b1;
      end
      // shift down: entry i-1 takes entry i
      oate_pkg::S_DN_RD: cmd.rd = oate_pkg::RD_I;
      oate_pkg::S_DN_WR: begin
        cmd.wr   = oate_pkg::WR_IM1_RDQ;
        cmd.i_op = oate_pkg::I_INC;
      end
      oate_pkg::S_DROP: cmd.cnt_dec = 1'b1;
      oate_pkg::S_RV_RA: cmd.rd = oate_pkg::RD_I;
      oate_pkg::S_RV_RB: begin
        cmd.rd      = oate_pkg::RD_J;
        cmd.hold_ld = 1'b1;
      end
      oate_pkg::S_RV_WA: cmd.wr = oate_pkg::WR_I_RDQ;
      oate_pkg::S_RV_WB: begin
        cmd.wr   = oate_pkg::WR_J_HOLD;
        cmd.i_op = oate_pkg::I_INC;
        cmd.j_op = oate_pkg::J_DEC;
      end
      oate_pkg::S_SCAN_RD: cmd.rd = oate_pkg::RD_I;
      oate_pkg::S_SCAN_EV: begin
        cmd.acc_add = 1'b1;
        if (stat.op == oate_pkg::OP_SEARCH && stat.match) begin
          cmd.found_ld = 1'b1;
        end else if (stat.i_more) begin
          cmd.i_op = oate_pkg::I_INC;
        end else if (stat.op == oate_pkg::OP_SEARCH) begin
          cmd.set_st = 1'b1;
          cmd.st     = oate_pkg::STS_NOTFOUND;
        end
      end
      oate_pkg::S_RD:  cmd.rd   = oate_pkg::RD_PM1;
      oate_pkg::S_FIN: cmd.emit = 1'b1;
      default:         cmd.load = 1'b0;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == oate_pkg::S_DECIDE)
    else $error("accepted item did not enter the decode step");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cmd.wr == oate_pkg::WR_NONE && cmd.rd == oate_pkg::RD_NONE &&
               !cmd.cnt_inc && !cmd.cnt_dec))
    else $error("memory or count touched while idle");

  a_emit_ends_item: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !busy)
    else $error("sequencer still busy after the result");

endmodule

### rtl/core/ordered_array_table_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_table_engine
// a rejected item goes from decode straight to finish; append, delete last,
//   read and an insert or delete with no tail to move add one step; insert,
//   delete, reverse, sum and search walk the single-port entry memory two
//   steps (four for a reverse swap) per entry
// throughput: one item at a time; start is taken again in the cycle done is high,
//   and the receiver cannot stall
// reset: synchronous; clears the fill count and sequencer, entries are not cleared
// ----------------------------------------------------------------------------
module ordered_array_table_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  oate_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output oate_pkg::rsp_t rsp
);

  oate_pkg::cmd_t     cmd;
  oate_pkg::dp_stat_t stat;

  oate_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  oate_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp),
    .done (done)
  );

endmodule
